FILE: rtl/core/pde_pkg.sv
// Package with the shared types, widths and helper functions of the pairwise distance engine.
`default_nettype none

package pde_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SUM_W      = 2 * DIFF_W;
    localparam int DIST_W     = 25;
    localparam int IDX_OUT_W  = 6;
    localparam int IN_DATA_W  = 3 * COORD_W;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * IDX_OUT_W - DIST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STORE,
        S_FETCH,
        S_SUM,
        S_ROOT,
        S_OUT,
        S_OVF
    } pde_state_t;

    typedef enum logic [1:0] {
        CRD_X,
        CRD_Y,
        CRD_Z
    } coord_sel_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } pde_term_ctl_t;

    function automatic coord_sel_t sel_advance(input coord_sel_t sel);
        coord_sel_t nxt;
        case (sel)
            CRD_X:   nxt = CRD_Y;
            CRD_Y:   nxt = CRD_Z;
            CRD_Z:   nxt = CRD_X;
            default: nxt = CRD_X;
        endcase
        return nxt;
    endfunction

    function automatic logic [COORD_W-1:0] coord_mux(
        input coord_sel_t         sel,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        logic [COORD_W-1:0] res;
        case (sel)
            CRD_X:   res = x;
            CRD_Y:   res = y;
            CRD_Z:   res = z;
            default: res = x;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pde_coord_mem.sv
// Coordinate memory holding x, y and z words of every stored point.
`default_nettype none

module pde_coord_mem
    import pde_pkg::*;
#(
    parameter int DEPTH = 192,
    parameter int AW    = 8
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [COORD_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [COORD_W-1:0] rdata
);

    logic [COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pde_sq_accum.sv
// Shared difference, square and accumulate unit that sums one squared term per coordinate.
`default_nettype none

module pde_sq_accum
    import pde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pde_term_ctl_t      term_ctl,
    input  wire logic [COORD_W-1:0] new_coord,
    input  wire logic [COORD_W-1:0] old_coord,
    output logic      [SUM_W-1:0]   sum,
    output logic                    sum_done
);

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] mag;
    logic        [SUM_W-1:0]  sq_prod;

    pde_term_ctl_t            ctl1_reg;
    pde_term_ctl_t            ctl2_reg;
    logic        [DIFF_W-1:0] mag_reg;
    logic        [SUM_W-1:0]  sq_reg;
    logic        [SUM_W-1:0]  acc_reg;
    logic                     done_reg;

    assign diff    = $signed({new_coord[COORD_W-1], new_coord})
                   - $signed({old_coord[COORD_W-1], old_coord});
    assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign sq_prod = SUM_W'(mag_reg) * SUM_W'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= term_ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid & ctl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term_ctl.valid)
        begin
            mag_reg <= mag;
        end
        if (ctl1_reg.valid)
        begin
            sq_reg <= sq_prod;
        end
        if (ctl2_reg.valid)
        begin
            acc_reg <= ctl2_reg.first ? sq_reg : acc_reg + sq_reg;
        end
    end

    assign sum      = acc_reg;
    assign sum_done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pde_isqrt.sv
// Iterative integer square root that resolves one root bit per clock cycle.
`default_nettype none

module pde_isqrt
    import pde_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  radicand,
    output logic      [DIST_W-1:0] root,
    output logic                   done
);

    localparam int STEPS  = DIST_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int REM_W  = DIST_W + 1;
    localparam int TRY_W  = REM_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;

    logic [TRY_W-1:0]  rem_sh;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  rem_sub;
    logic              take;
    logic [REM_W-1:0]  rem_next;

    assign rem_sh   = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign take     = rem_sh >= trial;
    assign rem_sub  = rem_sh - trial;
    assign rem_next = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[DIST_W-2:0], take};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pairwise_distance_engine.sv
// Top level of the pairwise distance engine with its sequencer and stream ports.
//
// Each accepted point is written to the coordinate memory a word at a time and then paired
// with every stored point, oldest first; each pair fetches its three coordinates through
// the single memory read port, runs them through one shared difference and square unit,
// and takes a 25 step bit-serial square root; a result waits until the output takes it.
// The input is not ready while a point is in work. A point that finds the set full gives
// a single overflow transaction and is dropped; start_set empties the set first.
`default_nettype none

module pairwise_distance_engine
    import pde_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: new_x, new_y, new_z.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: start_set.
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0 up: newer_index, older_index, distance, zero padding.
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    // Fields from bit 0 up: overflow.
    output logic      [0:0]            m_axis_tuser
);

    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int J_W       = $clog2(MAX_POINTS);
    localparam int MEM_DEPTH = 3 * MAX_POINTS;
    localparam int AW        = $clog2(MEM_DEPTH);

    pde_state_t         state_reg;
    pde_state_t         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [J_W-1:0]     j_reg;
    logic [AW-1:0]      base_reg;
    coord_sel_t         sel_reg;
    coord_sel_t         sel_d_reg;
    pde_term_ctl_t      ctl_d_reg;
    logic [COORD_W-1:0] new_x_reg;
    logic [COORD_W-1:0] new_y_reg;
    logic [COORD_W-1:0] new_z_reg;

    logic               accept;
    logic [CNT_W-1:0]   count_eff;
    logic               sel_last;
    logic               pair_last;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [COORD_W-1:0] mem_wdata;
    logic [COORD_W-1:0] mem_rdata;
    pde_term_ctl_t      fetch_ctl;
    logic [SUM_W-1:0]   sum;
    logic               sum_done;
    logic               root_start;
    logic [DIST_W-1:0]  root;
    logic               root_done;

    assign accept    = s_axis_tvalid & s_axis_tready;
    assign count_eff = s_axis_tuser[0] ? '0 : count_reg;
    assign sel_last  = (sel_reg == CRD_Z);
    assign pair_last = (CNT_W'(j_reg) + 1'b1) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_eff >= CNT_W'(MAX_POINTS)) ? S_OVF : S_STORE;
                end
            end
            S_STORE:
            begin
                if (sel_last)
                begin
                    state_next = (count_reg == '0) ? S_IDLE : S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (sel_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sum_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = pair_last ? S_IDLE : S_FETCH;
                end
            end
            S_OVF:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        fetch_ctl     = '0;
        root_start    = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tlast  = 1'b0;
        m_axis_tuser  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_STORE:
            begin
                mem_we = 1'b1;
            end
            S_FETCH:
            begin
                mem_re          = 1'b1;
                fetch_ctl.valid = 1'b1;
                fetch_ctl.first = (sel_reg == CRD_X);
                fetch_ctl.last  = sel_last;
            end
            S_SUM:
            begin
                root_start = sum_done;
            end
            S_ROOT:
            begin
                root_start = 1'b0;
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata  = {{OUT_PAD_W{1'b0}}, root, IDX_OUT_W'(j_reg),
                                 IDX_OUT_W'(count_reg)};
                m_axis_tlast  = pair_last;
            end
            S_OVF:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
                m_axis_tuser  = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign mem_waddr = AW'(count_reg) + (AW'(count_reg) << 1) + AW'(sel_reg);
    assign mem_raddr = base_reg + AW'(sel_reg);
    assign mem_wdata = coord_mux(sel_reg, new_x_reg, new_y_reg, new_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            j_reg     <= '0;
            base_reg  <= '0;
            sel_reg   <= CRD_X;
            sel_d_reg <= CRD_X;
            ctl_d_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_d_reg <= sel_reg;
            ctl_d_reg <= fetch_ctl;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_eff;
                        sel_reg   <= CRD_X;
                    end
                end
                S_STORE:
                begin
                    sel_reg <= sel_advance(sel_reg);
                    if (sel_last)
                    begin
                        j_reg    <= '0;
                        base_reg <= '0;
                        if (count_reg == '0)
                        begin
                            count_reg <= CNT_W'(1);
                        end
                    end
                end
                S_FETCH:
                begin
                    sel_reg <= sel_advance(sel_reg);
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (pair_last)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            j_reg    <= j_reg + 1'b1;
                            base_reg <= base_reg + AW'(3);
                        end
                    end
                end
                default:
                begin
                    sel_reg <= sel_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_x_reg <= s_axis_tdata[COORD_W-1:0];
            new_y_reg <= s_axis_tdata[2*COORD_W-1:COORD_W];
            new_z_reg <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
        end
    end

    pde_coord_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pde_sq_accum u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .term_ctl  (ctl_d_reg),
        .new_coord (coord_mux(sel_d_reg, new_x_reg, new_y_reg, new_z_reg)),
        .old_coord (mem_rdata),
        .sum       (sum),
        .sum_done  (sum_done)
    );

    pde_isqrt u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum),
        .root     (root),
        .done     (root_done)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pde_checker.sv
// Port-level checker of the pairwise distance engine and its bind to the top level.
`default_nettype none

module pde_checker
    import pde_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [0:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic [0:0]            m_axis_tuser
);

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result transaction changed");

    // The block never takes a point while a result is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // An overflow result is the only result of its point and carries zero data.
    a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed overflow result");

    // Once a point is taken the input stays closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

endmodule

bind pairwise_distance_engine pde_checker u_pde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
